>>> rtl/sact_pkg.sv
// Package: shared types and constants of the set-associative cache tag model.
package sact_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_WAYS        = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT = 2'd3;

  // Replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Reset values of the registers
  localparam logic [3:0] WAYS_RESET        = 4'd1;
  localparam logic [3:0] SET_BITS_RESET    = 4'd0;
  localparam logic [4:0] OFFSET_BITS_RESET = 5'd6;

  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 32;

  typedef struct packed {
    logic [3:0] ways;
    logic [3:0] set_bits;
    logic [4:0] offset_bits;
    logic       replacement;
  } cfg_t;

endpackage

>>> rtl/set_assoc_cache_tag_model.sv
// Top level: set-associative cache tag model with FIFO or LRU replacement.
//
// Input stream (s_*): one beat per access, func and byte address.
// Output stream (m_*): one beat per access: hit, memory read, memory write
// and the four saturating running totals after that access.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 ways,
// 1 set bits, 2 offset bits, 3 replacement); write only while idle.
// Reset: a clearing pass zeroes the per-set fill counts of all 2^MAX_SET_BITS
// sets (1024 by default), one set per cycle; s_tready stays low until it ends.
// A result beat is registered after the queue, the set read and the compare.
// Each access holds the back end through the read-then-update of the
// single tag RAM row (registered read, compare of all ways, write back).
// A two-entry queue between front and back takes input beats while the back
// works; a stalled m_tready holds the result register and the back end, and
// s_tready drops once the queue is full.
module set_assoc_cache_tag_model #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 10,
  parameter int ADDRESS_BITS = 48,
  localparam int IN_W = ((ADDRESS_BITS + 8) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_W-1:0]                 s_tdata,  // func, address, zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit, memory_read, memory_write, hit_total, miss_total, read_total,
  // write_total, zero fill
  output logic [135:0]                    m_tdata
);

  localparam int SETW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int QW   = 1 + SETW + ADDRESS_BITS;

  sact_pkg::cfg_t cfg;
  logic           clearing;
  logic           q_valid;
  logic [QW-1:0]  q_item;
  logic           q_pop;
  logic           hit;
  logic           memory_read;
  logic           memory_write;
  logic [31:0]    hit_total;
  logic [31:0]    miss_total;
  logic [31:0]    read_total;
  logic [31:0]    write_total;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ways        <= sact_pkg::WAYS_RESET;
      cfg.set_bits    <= sact_pkg::SET_BITS_RESET;
      cfg.offset_bits <= sact_pkg::OFFSET_BITS_RESET;
      cfg.replacement <= sact_pkg::POLICY_FIFO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sact_pkg::REG_WAYS:        cfg.ways        <= cfg_data[3:0];
        sact_pkg::REG_SET_BITS:    cfg.set_bits    <= cfg_data[3:0];
        sact_pkg::REG_OFFSET_BITS: cfg.offset_bits <= cfg_data[4:0];
        sact_pkg::REG_REPLACEMENT: cfg.replacement <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sact_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold       (clearing),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tdata[0]),
    .in_address (s_tdata[ADDRESS_BITS:1]),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  sact_back #(
    .MAX_WAYS     (MAX_WAYS),
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .hit          (hit),
    .memory_read  (memory_read),
    .memory_write (memory_write),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .read_total   (read_total),
    .write_total  (write_total)
  );

  assign m_tdata = {5'd0, write_total, read_total, miss_total, hit_total,
                    memory_write, memory_read, hit};

endmodule

>>> rtl/sact_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sact_front.sv
// Front end: accepts accesses, splits the address into set and tag, queues them.
module sact_front #(
  parameter int MAX_SET_BITS = 10,
  parameter int ADDRESS_BITS = 48,
  localparam int SETW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int QW   = 1 + SETW + ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sact_pkg::cfg_t          cfg,
  input  logic                    hold,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [ADDRESS_BITS-1:0] in_address,
  output logic                    q_valid,
  output logic [QW-1:0]           q_item,
  input  logic                    q_pop
);

  logic [4:0]              sb_eff;
  logic [6:0]              tag_shift;
  logic [ADDRESS_BITS-1:0] idx_full;
  logic [SETW-1:0]         set_mask;
  logic [SETW-1:0]         set_idx;
  logic [ADDRESS_BITS-1:0] tag;
  logic [QW-1:0]           slot [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  logic                    push;

  // Classify: saturate set bits, extract set index and tag
  always_comb begin
    sb_eff = ({1'b0, cfg.set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                       : {1'b0, cfg.set_bits};
    tag_shift = 7'(cfg.offset_bits) + 7'(sb_eff);
    idx_full  = in_address >> cfg.offset_bits;
    set_mask  = ~({SETW{1'b1}} << sb_eff);
    set_idx   = idx_full[SETW-1:0] & set_mask;
    tag       = in_address >> tag_shift;
  end

  assign in_ready = (count != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  // Two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {in_func, set_idx, tag};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/sact_back.sv
// Back end: clears the sets, looks up and updates a set, counts, holds the result.
module sact_back #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 10,
  parameter int ADDRESS_BITS = 48,
  localparam int SETW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int DEPTH = 1 << MAX_SET_BITS,
  localparam int FW    = $clog2(MAX_WAYS + 1),
  localparam int WAYW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int RW    = FW + MAX_WAYS * ADDRESS_BITS,
  localparam int QW    = 1 + SETW + ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sact_pkg::cfg_t          cfg,
  output logic                    clearing,
  input  logic                    q_valid,
  input  logic [QW-1:0]           q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic                    memory_read,
  output logic                    memory_write,
  output logic [31:0]             hit_total,
  output logic [31:0]             miss_total,
  output logic [31:0]             read_total,
  output logic [31:0]             write_total
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CMP} state_t;

  state_t                  state;
  logic [SETW-1:0]         clr_addr;
  logic                    cur_func;
  logic [SETW-1:0]         cur_set;
  logic [ADDRESS_BITS-1:0] cur_tag;

  logic                    ram_we;
  logic [SETW-1:0]         ram_waddr;
  logic [RW-1:0]           ram_wdata;
  logic [SETW-1:0]         ram_raddr;
  logic [RW-1:0]           ram_rdata;

  logic [FW-1:0]           w_eff;
  logic [FW-1:0]           n_eff;
  logic [FW-1:0]           fill_rd;
  logic [FW-1:0]           fill_new;
  logic [ADDRESS_BITS-1:0] line     [MAX_WAYS];
  logic [ADDRESS_BITS-1:0] line_new [MAX_WAYS];
  logic [MAX_WAYS-1:0]     match;
  logic [FW-1:0]           hit_way;
  logic                    found;
  logic                    advance;

  sact_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Look up the set row and build the updated row
  always_comb begin
    w_eff = ({1'b0, cfg.ways} > 5'(MAX_WAYS)) ? FW'(MAX_WAYS) : FW'(cfg.ways);
    if (cfg.ways == 4'd0) w_eff = FW'(1);
    fill_rd = ram_rdata[FW-1:0];
    n_eff   = (fill_rd > w_eff) ? w_eff : fill_rd;
    for (int k = 0; k < MAX_WAYS; k++) begin
      line[k]  = ram_rdata[FW + k*ADDRESS_BITS +: ADDRESS_BITS];
      match[k] = (FW'(k) < n_eff) && (line[k] == cur_tag);
    end
    found   = |match;
    hit_way = '0;
    for (int k = MAX_WAYS - 1; k >= 0; k--) begin
      if (match[k]) hit_way = FW'(k);
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      line_new[k] = line[k];
      if (found) begin
        if (cfg.replacement == sact_pkg::POLICY_LRU && FW'(k) >= hit_way) begin
          if (FW'(k) + FW'(1) < n_eff) line_new[k] = line[(k + 1) % MAX_WAYS];
          else if (FW'(k) + FW'(1) == n_eff) line_new[k] = line[hit_way[WAYW-1:0]];
        end
      end else if (n_eff < w_eff) begin
        if (FW'(k) == n_eff) line_new[k] = cur_tag;
      end else begin
        if (FW'(k) + FW'(1) < w_eff) line_new[k] = line[(k + 1) % MAX_WAYS];
        else if (FW'(k) + FW'(1) == w_eff) line_new[k] = cur_tag;
      end
    end
    if (found) fill_new = n_eff;
    else if (n_eff < w_eff) fill_new = n_eff + FW'(1);
    else fill_new = w_eff;
  end

  assign advance  = (state == S_CMP) && (!out_valid || out_ready);
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && q_valid;

  // Drive the RAM: zero rows while clearing, updated row on completion;
  // keep reading the current set while the compare waits
  always_comb begin
    ram_raddr = (state == S_CMP) ? cur_set : q_item[QW-2 -: SETW];
    ram_we    = 1'b0;
    ram_waddr = cur_set;
    ram_wdata = {RW{1'b0}};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (advance) begin
      ram_we       = 1'b1;
      ram_wdata[FW-1:0] = fill_new;
      for (int k = 0; k < MAX_WAYS; k++) begin
        ram_wdata[FW + k*ADDRESS_BITS +: ADDRESS_BITS] = line_new[k];
      end
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      hit_total   <= '0;
      miss_total  <= '0;
      read_total  <= '0;
      write_total <= '0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SETW'(1);
          if (clr_addr == SETW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_func <= q_item[QW-1];
            cur_set  <= q_item[QW-2 -: SETW];
            cur_tag  <= q_item[ADDRESS_BITS-1:0];
            state    <= S_CMP;
          end
        end
        S_CMP: begin
          if (advance) begin
            hit          <= found;
            memory_read  <= !found;
            memory_write <= (cur_func == sact_pkg::FUNC_WRITE);
            if (found && hit_total != '1) hit_total <= hit_total + 32'd1;
            if (!found && miss_total != '1) miss_total <= miss_total + 32'd1;
            if (!found && read_total != '1) read_total <= read_total + 32'd1;
            if (cur_func == sact_pkg::FUNC_WRITE && write_total != '1) begin
              write_total <= write_total + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
